[rtl/md5ce_pkg.sv]
// Shared types, constants and round tables for the MD5 compression engine.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package md5ce_pkg;

    localparam int WordW      = 32;
    localparam int BlockWords = 16;
    localparam int WordIdxW   = $clog2(BlockWords);
    localparam int Rounds     = 64;
    localparam int RoundIdxW  = $clog2(Rounds);
    localparam int DigestW    = 4 * WordW;

    localparam logic [WordW-1:0] IvA = 32'h67452301;
    localparam logic [WordW-1:0] IvB = 32'hefcdab89;
    localparam logic [WordW-1:0] IvC = 32'h98badcfe;
    localparam logic [WordW-1:0] IvD = 32'h10325476;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_INIT,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                 store_word;
        logic [WordIdxW-1:0]  word_idx;
        logic                 restart;
        logic                 init_round;
        logic                 run_round;
        logic [RoundIdxW-1:0] round_idx;
        logic [RoundIdxW-1:0] mk_idx;
        logic                 add_chain;
        logic                 load_out;
    } cmd_t;

    // Additive constants derived from the sine function.
    function automatic logic [WordW-1:0] md5_k(input logic [RoundIdxW-1:0] i);
        logic [WordW-1:0] k;
        case (i)
            6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
            6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
            6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
            6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
            6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
            6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
            6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
            6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
            6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
            6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
            6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
            6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
            6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
            6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
            6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
            6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
            6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
            6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
            6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
            6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
            6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
            6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
            6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
            6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
            6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
            6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
            6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
            6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
            6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
            6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
            6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // Rotate amount: depends on the phase and the low two bits of the round.
    function automatic logic [4:0] md5_rot(input logic [RoundIdxW-1:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index used in a given round, modulo sixteen.
    function automatic logic [WordIdxW-1:0] md5_g(input logic [RoundIdxW-1:0] i);
        logic [WordIdxW-1:0] lo;
        logic [WordIdxW-1:0] g;
        lo = i[WordIdxW-1:0];
        case (i[5:4])
            2'd0:    g = lo;
            2'd1:    g = WordIdxW'(lo * 4'd5) + 4'd1;
            2'd2:    g = WordIdxW'(lo * 4'd3) + 4'd5;
            default: g = WordIdxW'(lo * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [WordW-1:0] md5_rotl(input logic [WordW-1:0] v,
                                                  input logic [4:0] s);
        logic [2*WordW-1:0] dbl;
        dbl = {v, v} << s;
        return dbl[2*WordW-1:WordW];
    endfunction

endpackage

`default_nettype wire

[rtl/md5_compression_engine.sv]
// MD5 compression engine, top level: ties the controller to the datapath.
// After the sixteenth word of a final block is taken, the engine runs init, the rounds and
// the chaining update, then loads the digest in the emit state once any earlier digest is
// taken. Words of the next block wait until the current block is through the one round unit.
// Reset (aresetn low, synchronous): chaining value returns to the MD5 initial constants,
// the word count and final flag clear, and no digest is pending.
`default_nettype none

module md5_compression_engine (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Input requests: one padded message word each.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] message_word
    input  wire logic [1:0]   s_tuser,   // [0] new_message, [1] final_block
    // Result requests: one digest per completed final block.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [127:0] m_tdata    // [31:0] digest_a, [63:32] digest_b,
                                         // [95:64] digest_c, [127:96] digest_d
);

    md5ce_pkg::cmd_t cmd;

    // The controller sequences word collection, the 64 rounds and the output request.
    // Words are taken only while a block is being collected; during compression the
    // input side is held off because the block buffer is being read.
    md5ce_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .new_message (s_tuser[0]),
        .final_block (s_tuser[1]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cmd         (cmd)
    );

    // The datapath holds the block buffer, chaining value, working registers and the
    // output register, so a finished digest waits there while the next block collects.
    md5ce_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .word_in    (s_tdata),
        .digest_out (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/md5ce_datapath.sv]
// Datapath of the MD5 engine: block buffer, chaining value, round registers
// and digest output register. Uses md5ce_pkg; driven by md5ce_ctrl commands.
`default_nettype none

module md5ce_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire md5ce_pkg::cmd_t               cmd,
    input  wire logic [md5ce_pkg::WordW-1:0]   word_in,
    output logic      [md5ce_pkg::DigestW-1:0] digest_out
);

    logic [md5ce_pkg::WordW-1:0] buf_reg [md5ce_pkg::BlockWords];
    logic [md5ce_pkg::WordW-1:0] chain_reg [4];
    logic [md5ce_pkg::WordW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [md5ce_pkg::WordW-1:0] mk_reg, mk_next;
    logic [md5ce_pkg::WordW-1:0] f_val, sum_val, b_next;
    logic [md5ce_pkg::DigestW-1:0] out_reg;

    // Message word plus round constant is fetched one round ahead.
    assign mk_next = buf_reg[md5ce_pkg::md5_g(cmd.mk_idx)] + md5ce_pkg::md5_k(cmd.mk_idx);

    always_comb begin
        case (cmd.round_idx[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum_val = a_reg + f_val + mk_reg;
        b_next  = b_reg + md5ce_pkg::md5_rotl(sum_val, md5ce_pkg::md5_rot(cmd.round_idx));
    end

    always_ff @(posedge aclk) begin
        if (cmd.store_word) begin
            buf_reg[cmd.word_idx] <= word_in;
        end
        if (cmd.init_round || cmd.run_round) begin
            mk_reg <= mk_next;
        end
        if (cmd.init_round) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end else if (cmd.run_round) begin
            a_reg <= d_reg;
            b_reg <= b_next;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
        if (cmd.load_out) begin
            out_reg <= {chain_reg[3], chain_reg[2], chain_reg[1], chain_reg[0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.restart) begin
            chain_reg[0] <= md5ce_pkg::IvA;
            chain_reg[1] <= md5ce_pkg::IvB;
            chain_reg[2] <= md5ce_pkg::IvC;
            chain_reg[3] <= md5ce_pkg::IvD;
        end else if (cmd.add_chain) begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
        end
    end

    assign digest_out = out_reg;

endmodule

`default_nettype wire

[rtl/md5ce_ctrl.sv]
// Controller of the MD5 engine: word collection, round sequencing and the
// result handshake. Uses md5ce_pkg; issues md5ce_pkg::cmd_t to the datapath.
`default_nettype none

module md5ce_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic            new_message,
    input  wire logic            final_block,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output md5ce_pkg::cmd_t      cmd
);

    md5ce_pkg::state_t state_reg, state_next;
    logic [md5ce_pkg::WordIdxW-1:0]  word_count_reg, word_count_next;
    logic [md5ce_pkg::RoundIdxW-1:0] round_reg, round_next;
    logic last_seen_reg, last_seen_next;
    logic out_valid_reg, out_valid_next;
    logic accept;
    logic [md5ce_pkg::WordIdxW-1:0] idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= md5ce_pkg::ST_COLLECT;
            word_count_reg <= '0;
            round_reg      <= '0;
            last_seen_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            word_count_reg <= word_count_next;
            round_reg      <= round_next;
            last_seen_reg  <= last_seen_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        word_count_next = word_count_reg;
        round_next      = round_reg;
        last_seen_next  = last_seen_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        s_tready        = 1'b0;
        accept          = 1'b0;
        idx             = new_message ? '0 : word_count_reg;
        cmd             = '0;
        cmd.word_idx    = idx;
        cmd.round_idx   = round_reg;
        cmd.mk_idx      = round_reg + 1'b1;

        unique case (state_reg)
            md5ce_pkg::ST_COLLECT: begin
                s_tready = 1'b1;
                accept   = s_tvalid;
                if (accept) begin
                    cmd.store_word  = 1'b1;
                    cmd.restart     = new_message;
                    last_seen_next  = (last_seen_reg && !new_message) || final_block;
                    word_count_next = idx + 1'b1;
                    if (idx == md5ce_pkg::WordIdxW'(md5ce_pkg::BlockWords - 1)) begin
                        state_next = md5ce_pkg::ST_INIT;
                    end
                end
            end
            md5ce_pkg::ST_INIT: begin
                cmd.init_round = 1'b1;
                cmd.mk_idx     = '0;
                round_next     = '0;
                state_next     = md5ce_pkg::ST_ROUND;
            end
            md5ce_pkg::ST_ROUND: begin
                cmd.run_round = 1'b1;
                round_next    = round_reg + 1'b1;
                if (round_reg == md5ce_pkg::RoundIdxW'(md5ce_pkg::Rounds - 1)) begin
                    state_next = md5ce_pkg::ST_UPDATE;
                end
            end
            md5ce_pkg::ST_UPDATE: begin
                cmd.add_chain = 1'b1;
                state_next    = last_seen_reg ? md5ce_pkg::ST_EMIT : md5ce_pkg::ST_COLLECT;
            end
            md5ce_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    last_seen_next = 1'b0;
                    state_next     = md5ce_pkg::ST_COLLECT;
                end
            end
            default: state_next = md5ce_pkg::ST_COLLECT;
        endcase
    end

    assign m_tvalid = out_valid_reg;

`ifndef ASSERT_OFF
    // Compression starts only with a full block and an empty word counter.
    a_init_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == md5ce_pkg::ST_INIT |-> word_count_reg == '0)
        else $error("compression started with a partial block");

    // The last round is always followed by the chaining update.
    a_round_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5ce_pkg::ST_ROUND &&
         round_reg == md5ce_pkg::RoundIdxW'(md5ce_pkg::Rounds - 1))
        |=> state_reg == md5ce_pkg::ST_UPDATE)
        else $error("round sequence did not end in the update");

    // A new digest never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("digest overwritten while still pending");

    // A digest is only emitted for a block marked final.
    a_emit_final: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == md5ce_pkg::ST_EMIT |-> last_seen_reg)
        else $error("digest emitted for a non-final block");
`endif

endmodule

`default_nettype wire

[sim/md5_compression_engine_tb.sv]
// Self-checking testbench for md5_compression_engine: streams padded message words,
// predicts every digest with a behavioral MD5 model and checks each result request.
// Depends on rtl/md5ce_pkg.sv and rtl/md5_compression_engine.sv.
`timescale 1ns / 1ps

module md5_compression_engine_tb;

    // Roughly how many message words the run streams, the directed part included.
    localparam int WordTarget  = 1950;
    // Watchdog bound on the whole run, set generously above what the run normally needs.
    localparam int CycleLimit  = 400000;
    // Idle this long at the end to catch late or stray results.
    localparam int DrainCycles = 150;

    // Additive constants, one per round.
    localparam logic [31:0] SineAdd [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    // Left-rotate amounts. The index is the phase times four plus the low two round bits.
    localparam int RotAmount [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                      4, 11, 16, 23, 6, 10, 15, 21};

    // Digest predictor and checker. Every accepted word updates a model of the engine.
    // Each completed final block queues the digest that the engine must return.
    class md5_scoreboard;
        logic [31:0]  block_words [md5ce_pkg::BlockWords];
        logic [31:0]  chain [4];
        int unsigned  word_cnt;
        bit           final_seen;
        logic [127:0] digest_q [$];
        int unsigned  words_taken;
        int unsigned  digests_checked;
        int unsigned  mismatches;

        function new();
            chain = '{md5ce_pkg::IvA, md5ce_pkg::IvB, md5ce_pkg::IvC, md5ce_pkg::IvD};
            word_cnt        = 0;
            final_seen      = 1'b0;
            words_taken     = 0;
            digests_checked = 0;
            mismatches      = 0;
        endfunction

        function int unsigned pending();
            return digest_q.size();
        endfunction

        // Account for one accepted input request.
        function void note_request(logic [31:0] word, bit new_msg, bit fin);
            logic [31:0] a, b, c, d, f, t;
            int unsigned g, phase, s;
            words_taken++;
            // A new message drops any partial block and restarts the chain.
            if (new_msg) begin
                chain      = '{md5ce_pkg::IvA, md5ce_pkg::IvB, md5ce_pkg::IvC, md5ce_pkg::IvD};
                word_cnt   = 0;
                final_seen = 1'b0;
            end
            block_words[word_cnt] = word;
            // A final flag on any word marks the whole block as final.
            if (fin)
                final_seen = 1'b1;
            word_cnt++;
            if (word_cnt < md5ce_pkg::BlockWords)
                return;
            word_cnt = 0;

            // Run the 64 rounds, then add the result into the chaining value.
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int unsigned i = 0; i < 64; i++) begin
                phase = i / 16;
                case (phase)
                    0: begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1: begin
                        f = (b & d) | (c & ~d);
                        g = 1 + 5 * i;
                    end
                    2: begin
                        f = b ^ c ^ d;
                        g = 5 + 3 * i;
                    end
                    default: begin
                        f = c ^ (b | ~d);
                        g = 7 * i;
                    end
                endcase
                t = a + f + block_words[g % 16] + SineAdd[i];
                s = RotAmount[phase * 4 + i % 4];
                t = b + ((t << s) | (t >> (32 - s)));
                a = d;
                d = c;
                c = b;
                b = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;

            // The chain is kept after a digest, so later blocks keep chaining from it.
            if (final_seen) begin
                final_seen = 1'b0;
                digest_q.push_back({chain[3], chain[2], chain[1], chain[0]});
            end
        endfunction

        // Compare one accepted digest with the oldest one still due.
        function void check_digest(logic [127:0] got);
            logic [127:0] want;
            if (digest_q.size() == 0) begin
                $display("%0t: digest %h arrived with none expected", $time, got);
                mismatches++;
                return;
            end
            want = digest_q.pop_front();
            digests_checked++;
            for (int k = 0; k < 4; k++) begin
                if (got[32*k +: 32] !== want[32*k +: 32]) begin
                    $display("%0t: digest_%c expected %h actual %h", $time, 8'(97 + k),
                             want[32*k +: 32], got[32*k +: 32]);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;     // [0] new_message, [1] final_block
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;           // [31:0] a, [63:32] b, [95:64] c, [127:96] d

    md5_scoreboard digest_sb = new();

    // When set, the sender or the receiver runs without idle cycles.
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int unsigned cycle_cnt = 0;
    int unsigned msg_cnt   = 0;

    md5_compression_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog. A hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("%0t: run exceeded %0d cycles with %0d digests outstanding",
                     $time, CycleLimit, digest_sb.pending());
            $display("tb: failure");
            $finish;
        end
    end

    // Message words are mostly random, with a bias toward all-zero, all-one
    // and single-bit values, which stress the carry chains in the round adder.
    function automatic logic [31:0] draw_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Present one request after a random gap, then hold it until the engine takes it.
    // Valid stays high between back-to-back requests, so it gets one assignment per step.
    task automatic send_word(input logic [31:0] word, input bit new_msg, input bit fin);
        int unsigned gap;
        gap = tx_steady ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {fin, new_msg};
        do @(posedge aclk); while (!s_tready);
        digest_sb.note_request(word, new_msg, fin);
    endtask

    // Send a well-formed message of whole blocks. The last block is marked final, either
    // on every word or on one random word only. Without restart, the message chains from
    // whatever the previous message left in the chaining value.
    task automatic send_message(input int unsigned blocks, input bit restart,
                                input bit one_flag);
        int unsigned flag_pos;
        bit          last_blk;
        flag_pos = $urandom_range(0, 15);
        for (int unsigned blk = 0; blk < blocks; blk++) begin
            last_blk = (blk == blocks - 1);
            for (int unsigned w = 0; w < 16; w++)
                send_word(draw_word(), restart && blk == 0 && w == 0,
                          last_blk && (!one_flag || w == flag_pos));
        end
    endtask

    // Broken traffic: stray restarts and final flags at random points, with lengths
    // that usually leave a partial block behind.
    task automatic send_noise(input int unsigned words);
        for (int unsigned n = 0; n < words; n++)
            send_word(draw_word(), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
    endtask

    // Hold the sender until every expected digest has been returned. Valid is dropped and the
    // clock is always awaited first, so valid never gets a second assignment in the same step.
    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (digest_sb.pending() != 0) @(posedge aclk);
    endtask

    // Result side. In steady mode, ready stays high. Otherwise ready stays low until a
    // digest is offered, and then stays low for a random number of further cycles.
    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                stall = $urandom_range(0, 16);
                m_tready <= 1'b0;
                do @(posedge aclk); while (!m_tvalid);
                repeat (stall) @(posedge aclk);
                m_tready <= 1'b1;
            end
            do @(posedge aclk); while (!m_tvalid);
            digest_sb.check_digest(m_tdata);
        end
    end

    initial begin
        int unsigned pick;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. The first block arrives with no restart, so it chains from the
        // reset constants. It holds the extreme word values, and only one of its words
        // carries the final flag, which must still mark the whole block as final.
        send_word(32'h0000_0080, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0, 1'b0);
        send_word(32'h5555_5555, 1'b0, 1'b0);
        send_word(32'h8000_0000, 1'b0, 1'b0);
        send_word(32'h0000_0001, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFE, 1'b0, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h0F0F_0F0F, 1'b0, 1'b0);
        send_word(32'hF0F0_F0F0, 1'b0, 1'b0);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        // These words form a partial block. One of them carries a final flag. The restart
        // that opens the first random message must discard both the words and the flag.
        send_word(32'hDEAD_BEEF, 1'b0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_word(32'h0000_0000, 1'b0, 1'b0);
        send_word(32'h1234_5678, 1'b0, 1'b0);
        wait_for_digests();

        // Random part. Most traffic is well-formed messages. Some messages continue the
        // previous chain, and the rest is broken traffic. The first pick is forced to a
        // message that restarts the chain.
        while (digest_sb.words_taken < WordTarget) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            pick = (msg_cnt == 0) ? 0 : $urandom_range(0, 99);
            if (pick < 75)
                send_message($urandom_range(1, 3), 1'b1, $urandom_range(0, 1));
            else if (pick < 87)
                send_message($urandom_range(1, 2), 1'b0, $urandom_range(0, 1));
            else
                send_noise($urandom_range(1, 20));
            msg_cnt++;
            if (msg_cnt % 25 == 0)
                wait_for_digests();
        end

        wait_for_digests();
        repeat (DrainCycles) @(posedge aclk);

        $display("Streamed %0d words in %0d random messages plus a directed preamble.",
                 digest_sb.words_taken, msg_cnt);
        $display("Checked %0d digests. Mismatches: %0d. Still outstanding: %0d.",
                 digest_sb.digests_checked, digest_sb.mismatches, digest_sb.pending());
        if (digest_sb.mismatches == 0 && digest_sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[files.f]
rtl/md5ce_pkg.sv
rtl/md5ce_datapath.sv
rtl/md5ce_ctrl.sv
rtl/md5_compression_engine.sv
sim/md5_compression_engine_tb.sv
